// File: src/adf_pkg.sv
// Shared types and constants for the aging duplicate filter.
package adf_pkg;

   localparam int CMD_W        = 3;
   localparam int DIGEST_W     = 64;
   localparam int EPOCH_W      = 64;
   localparam int STEP_W       = 32;
   localparam int CUTOFF_W     = 32;
   localparam int REQ_TDATA_W  = 160;
   localparam int RSP_TDATA_W  = 8;

   localparam logic [CMD_W-1:0] CMD_APPLY     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CHECK     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ADVANCE   = 3'd4;

   // decoded operation; undefined commands become a no-op
   typedef enum logic [2:0] {
      OP_NOP,
      OP_APPLY,
      OP_CHECK,
      OP_CLEAR,
      OP_CLEAR_ALL,
      OP_ADVANCE
   } adf_op_type;

   typedef struct packed {
      adf_op_type            op;
      logic [DIGEST_W-1:0]   digest_hi;
      logic [DIGEST_W-1:0]   digest_lo;
      logic [STEP_W-1:0]     epoch_step;
   } adf_item_type;

   typedef struct packed {
      logic [DIGEST_W-1:0]   digest_hi;
      logic [DIGEST_W-1:0]   digest_lo;
      logic [EPOCH_W-1:0]    epoch;
   } adf_entry_type;

   // back-end status seen by the front end
   typedef struct packed {
      logic init_done;   // clearing pass after reset finished
   } adf_status_type;

endpackage

// File: src/adf_front.sv
// Front end: accepts request words, decodes the command, hands items to the queue.
module adf_front
   import adf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]       req_tuser,
   input  adf_status_type         status,
   output logic                   push_valid,
   input  logic                   push_ready,
   output adf_item_type           push_item
);

   logic         valid_ff, valid_in;
   adf_item_type item_ff, item_in;
   logic         accept;

   always_comb begin
      item_in.digest_hi  = req_tdata[63:0];
      item_in.digest_lo  = req_tdata[127:64];
      item_in.epoch_step = req_tdata[159:128];
      case (req_tuser)
         CMD_APPLY:     item_in.op = OP_APPLY;
         CMD_CHECK:     item_in.op = OP_CHECK;
         CMD_CLEAR:     item_in.op = OP_CLEAR;
         CMD_CLEAR_ALL: item_in.op = OP_CLEAR_ALL;
         CMD_ADVANCE:   item_in.op = OP_ADVANCE;
         default:       item_in.op = OP_NOP;
      endcase
   end

   assign req_tready = status.init_done && (!valid_ff || push_ready);
   assign accept     = req_tvalid && req_tready;
   assign valid_in   = accept || (valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

// File: src/adf_queue.sv
// Two-entry queue between the front end and the back end.
module adf_queue
   import adf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  adf_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output adf_item_type pop_item
);

   adf_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/adf_back.sv
// Back end: slot table, match logic, epoch counter, clearing sweep, result register.
module adf_back
   import adf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CUTOFF_W-1:0]    ttl_epochs,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  adf_item_type           pop_item,
   output adf_status_type         status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_SWEEP = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EVAL  = 3'b100
   } adf_state_type;

   adf_state_type state_ff, state_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic             init_done_ff, init_done_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   adf_item_type     cur_ff;

   adf_entry_type    table_mem [TABLE_ENTRIES];
   adf_entry_type    rd_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   adf_entry_type    mem_wdata;
   logic [IDX_W-1:0] rd_idx;

   logic             out_free;
   logic             digest_eq;
   logic [EPOCH_W:0] age_sum;
   logic             match;
   logic [EPOCH_W:0] adv_sum;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pop_ready = (state_ff == ST_IDLE);
   assign rd_idx    = pop_item.digest_lo[IDX_W-1:0];

   // stored epoch plus cutoff, one bit wider so the sum cannot wrap
   assign digest_eq = (rd_ff.digest_hi == cur_ff.digest_hi) &&
                      (rd_ff.digest_lo == cur_ff.digest_lo);
   assign age_sum   = {1'b0, rd_ff.epoch} + {{(EPOCH_W + 1 - CUTOFF_W){1'b0}}, ttl_epochs};
   assign match     = digest_eq && (age_sum >= {1'b0, epoch_ff});
   assign adv_sum   = {1'b0, epoch_ff} + {{(EPOCH_W + 1 - STEP_W){1'b0}}, cur_ff.epoch_step};

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      init_done_in = init_done_ff;
      epoch_in     = epoch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff.digest_lo[IDX_W-1:0];
      mem_wdata    = '0;
      case (state_ff)
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            if (sweep_ff == LAST_IDX) begin
               state_in     = ST_IDLE;
               init_done_in = 1'b1;
            end else begin
               sweep_in = sweep_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               state_in     = ST_IDLE;
               case (cur_ff.op)
                  OP_APPLY: begin
                     rsp_hit_in = match;
                     if (!match) begin
                        mem_we              = 1'b1;
                        mem_wdata.digest_hi = cur_ff.digest_hi;
                        mem_wdata.digest_lo = cur_ff.digest_lo;
                        mem_wdata.epoch     = epoch_ff;
                     end
                  end
                  OP_CHECK: begin
                     rsp_hit_in = match;
                  end
                  OP_CLEAR: begin
                     rsp_hit_in = match;
                     mem_we     = match;
                  end
                  OP_CLEAR_ALL: begin
                     state_in = ST_SWEEP;
                     sweep_in = '0;
                  end
                  OP_ADVANCE: begin
                     // saturate at the top of the epoch range
                     epoch_in = adv_sum[EPOCH_W] ? {EPOCH_W{1'b1}} : adv_sum[EPOCH_W-1:0];
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         init_done_ff <= 1'b0;
         epoch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         init_done_ff <= init_done_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
      if (pop_valid && pop_ready) begin
         cur_ff <= pop_item;
      end
   end

   // slot table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (pop_valid && pop_ready) begin
         rd_ff <= table_mem[rd_idx];
      end
   end

   assign status.init_done = init_done_ff;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = {{(RSP_TDATA_W - 1){1'b0}}, rsp_hit_ff};

endmodule

// File: src/aging_duplicate_filter_unit.sv
// Top level of the aging duplicate filter: front end, queue, back end, cutoff register.
// Path: a request passes the front stage, a queue slot and the table read; evaluate
//   loads the response register; a clear_all starts a sweep of all TABLE_ENTRIES slots after it.
// Pacing: the back end takes a new word only once it is done with the last one, set by the
//   read-then-write of one table slot; a clear_all holds the back end until its sweep ends.
// Reset: synchronous; the back end then sweeps all TABLE_ENTRIES slots to zero,
//   one per cycle, with req_tready low; csr writes are taken throughout.
module aging_duplicate_filter_unit
   import adf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024   // power of two, 2 .. 2**20
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // digest_hi[63:0], digest_lo[127:64],
                                              // epoch_step[159:128]
   input  logic [CMD_W-1:0]       req_tuser,  // cmd[2:0]
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // hit[0], zero fill[7:1]
   // age cutoff register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CUTOFF_W-1:0]    csr_wdata
);

   logic [CUTOFF_W-1:0] ttl_epochs_ff, ttl_epochs_in;
   adf_status_type      status;
   logic                push_valid, push_ready;
   adf_item_type        push_item;
   logic                pop_valid, pop_ready;
   adf_item_type        pop_item;

   // cutoff register; always writable; only to be changed while the unit is idle, which the block does not enforce
   assign csr_ready     = 1'b1;
   assign ttl_epochs_in = (csr_valid && csr_ready) ? csr_wdata : ttl_epochs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_epochs_ff <= '0;
      end else begin
         ttl_epochs_ff <= ttl_epochs_in;
      end
   end

   adf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decouples decode from the table read-modify-write
   adf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   adf_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .ttl_epochs (ttl_epochs_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: src/adf_checker.sv
// Port-level checks for the aging duplicate filter, bound to the top level.
module adf_checker
   import adf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [3:0] pending_ff, pending_in;
   logic       req_acc, rsp_acc;

   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign pending_in = pending_ff + {3'b0, req_acc} - {3'b0, rsp_acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // held response keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // no response without an accepted request behind it
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 4'd0)
      else $error("response without request");

   // at most front stage, two queue slots, back end and response register in flight
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'd5)
      else $error("too many words in flight");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:1] == '0)
      else $error("response fill bits set");

   // clearing pass holds off requests right after reset
   a_init_block: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("request taken during clearing pass");

endmodule

bind aging_duplicate_filter_unit adf_checker u_adf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: test/filter_checker.sv
// Scoreboard for the duplicate filter: predicts the hit bit of every request word and checks it.
`timescale 1ns / 1ps
module filter_checker
   import adf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]       req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CUTOFF_W-1:0]    csr_wdata,
   output int unsigned            errors,
   output int unsigned            pending,
   output int unsigned            responses,
   output int unsigned            hits
);

   localparam int SLOT_W = $clog2(TABLE_ENTRIES);

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [DIGEST_W-1:0] digest_lo;
      logic                hit;
   } hit_expectation_type;

   // shadow table and epoch state
   logic [DIGEST_W-1:0] shadow_hi    [TABLE_ENTRIES];
   logic [DIGEST_W-1:0] shadow_lo    [TABLE_ENTRIES];
   logic [EPOCH_W-1:0]  shadow_epoch [TABLE_ENTRIES];
   logic [EPOCH_W-1:0]  epoch_now;
   logic [CUTOFF_W-1:0] cutoff;
   hit_expectation_type expected_hits [$];

   function automatic void wipe_table();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         shadow_hi[i]    = '0;
         shadow_lo[i]    = '0;
         shadow_epoch[i] = '0;
      end
   endfunction

   // digest equal and not aged out; one extra bit keeps the sum from wrapping
   function automatic logic slot_live(input int unsigned s,
                                      input logic [DIGEST_W-1:0] hi, lo);
      logic [EPOCH_W:0] reach;
      if (shadow_hi[s] != hi || shadow_lo[s] != lo)
         return 1'b0;
      reach = {1'b0, shadow_epoch[s]} + (EPOCH_W+1)'(cutoff);
      return reach >= {1'b0, epoch_now};
   endfunction

   // applies one word to the shadow state and returns the hit it must produce
   function automatic logic predict_hit(input logic [CMD_W-1:0] cmd,
                                        input logic [DIGEST_W-1:0] hi, lo,
                                        input logic [STEP_W-1:0] step);
      int unsigned      s;
      logic [EPOCH_W:0] sum;
      logic             hit;
      s   = int'(lo[SLOT_W-1:0]);
      hit = 1'b0;
      case (cmd)
         CMD_APPLY: begin
            if (slot_live(s, hi, lo)) begin
               hit = 1'b1;
            end else begin
               shadow_hi[s]    = hi;
               shadow_lo[s]    = lo;
               shadow_epoch[s] = epoch_now;
            end
         end
         CMD_CHECK: begin
            hit = slot_live(s, hi, lo);
         end
         CMD_CLEAR: begin
            if (slot_live(s, hi, lo)) begin
               shadow_hi[s]    = '0;
               shadow_lo[s]    = '0;
               shadow_epoch[s] = '0;
               hit             = 1'b1;
            end
         end
         CMD_CLEAR_ALL: begin
            wipe_table();
         end
         CMD_ADVANCE: begin
            sum       = {1'b0, epoch_now} + (EPOCH_W+1)'(step);
            epoch_now = sum[EPOCH_W] ? '1 : sum[EPOCH_W-1:0];
         end
         default: begin
         end
      endcase
      return hit;
   endfunction

   always @(posedge clock) begin
      hit_expectation_type want;
      logic                got;
      if (reset) begin
         wipe_table();
         epoch_now = '0;
         cutoff    = '0;
         expected_hits.delete();
         errors    = 0;
         responses = 0;
         hits      = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[0];
            responses++;
            if (got === 1'b1)
               hits++;
            if (expected_hits.size() == 0) begin
               errors++;
               $display("%0t: response word with nothing expected: expected none, actual hit %b",
                        $time, got);
            end else begin
               want = expected_hits.pop_front();
               if (got !== want.hit) begin
                  errors++;
                  $display("%0t: hit mismatch, cmd %0d digest_lo %h: expected %b, actual %b",
                           $time, want.cmd, want.digest_lo, want.hit, got);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want.cmd       = req_tuser;
            want.digest_lo = req_tdata[2*DIGEST_W-1:DIGEST_W];
            want.hit       = predict_hit(req_tuser, req_tdata[DIGEST_W-1:0],
                                         req_tdata[2*DIGEST_W-1:DIGEST_W],
                                         req_tdata[2*DIGEST_W+STEP_W-1:2*DIGEST_W]);
            expected_hits.push_back(want);
         end
         if (csr_valid && csr_ready)
            cutoff = csr_wdata;
      end
      pending = expected_hits.size();
   end

endmodule

// File: test/tb.sv
// Testbench top for aging_duplicate_filter_unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
   import adf_pkg::*;

   localparam int TABLE_ENTRIES    = 1024;
   localparam int SLOT_W           = $clog2(TABLE_ENTRIES);
   localparam int WORDS_PER_PHASE  = 300;
   localparam int PHASES           = 5;
   localparam int POOL_SIZE        = 16;
   localparam int IDLE_PCT         = 17;
   localparam int HOLD_CYCLES      = 400;    // long receiver hold-off, fills the block
   localparam int SETTLE_CYCLES    = 8;      // a bit past the request-to-response latency
   localparam int DRAIN_CYCLES     = 50;
   localparam int QUIET_LIMIT      = 20000;  // covers reset sweep, clear_all sweeps, hold-off

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]       req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CUTOFF_W-1:0]    csr_wdata  = '0;

   int unsigned errors, pending, responses, hits;
   int unsigned cmd_seen [8];
   int unsigned quiet_cycles = 0;

   // calm: neither side idles; hold_pending: receiver starts its long hold-off
   bit calm         = 1'b0;
   bit hold_pending = 1'b0;

   // digests reused within a phase so that repeats, aging and clears happen
   logic [DIGEST_W-1:0] pool_hi [POOL_SIZE];
   logic [DIGEST_W-1:0] pool_lo [POOL_SIZE];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   aging_duplicate_filter_unit #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // digest_hi[63:0], digest_lo[127:64], epoch_step[159:128]
      .req_tuser  (req_tuser),   // cmd[2:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // hit[0], zero fill[7:1]
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   filter_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) hit_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .pending    (pending),
      .responses  (responses),
      .hits       (hits)
   );

   // Watchdog: any run of cycles with no word moving on any channel past the limit is a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response side: random backpressure, one long hold-off on request.
   // The hold-off and the next update fall on different falling edges.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   function automatic logic [DIGEST_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Sends one request word; entered and left at a falling edge.
   // Valid stays high between back-to-back words; it only drops for idle cycles.
   task automatic send_word(input logic [CMD_W-1:0] cmd,
                            input logic [DIGEST_W-1:0] hi, lo,
                            input logic [STEP_W-1:0] step);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {step, lo, hi};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cmd_seen[cmd]++;
      @(negedge clock);
   endtask

   task automatic write_cutoff(input logic [CUTOFF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Block idle: every expected response back, plus a settling margin.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic directed_words();
      logic [DIGEST_W-1:0] a_hi, a_lo, b_hi, b_lo;
      a_hi = '1;
      a_lo = '1;
      b_hi = 64'hFEDC_BA98_7654_3210;
      b_lo = 64'h0123_4567_89AB_C3FF;           // same slot as the all-ones digest
      send_word(CMD_CHECK, '0, '0, '0);         // empty slot looks like digest 0 at epoch 0
      send_word(CMD_APPLY, '0, '0, '1);
      send_word(CMD_APPLY, a_hi, a_lo, '0);     // miss, inserted
      send_word(CMD_APPLY, a_hi, a_lo, '0);     // duplicate
      send_word(CMD_CHECK, a_hi, a_lo, '0);
      send_word(CMD_CLEAR, a_hi, a_lo, '0);
      send_word(CMD_CHECK, a_hi, a_lo, '0);
      send_word(CMD_CLEAR, a_hi, a_lo, '0);     // nothing left to clear
      send_word(CMD_APPLY, b_hi, b_lo, '0);     // evicts from the shared slot
      send_word(CMD_CHECK, a_hi, a_lo, '0);
      send_word(CMD_ADVANCE, '0, '0, '0);       // zero step
      send_word(CMD_CHECK, b_hi, b_lo, '0);
      send_word(CMD_ADVANCE, a_hi, a_lo, 32'd1);
      send_word(CMD_CHECK, b_hi, b_lo, '0);     // aged out, cutoff 0
      send_word(CMD_CHECK, '0, '0, '0);         // empty slot aged out too
      send_word(CMD_APPLY, b_hi, b_lo, '0);
      send_word(CMD_ADVANCE, '0, '0, '1);       // largest step
      send_word(CMD_CHECK, b_hi, b_lo, '1);
      for (int u = 1; u <= 3; u++)              // undefined commands above advance
         send_word(CMD_ADVANCE + CMD_W'(u), rand64(), rand64(), $urandom);
      send_word(CMD_CLEAR_ALL, a_hi, a_lo, '1);
      send_word(CMD_CHECK, b_hi, b_lo, '0);
      send_word(CMD_APPLY, b_hi, b_lo, '0);
      send_word(CMD_CHECK, b_hi, b_lo, '0);
   endtask

   // Every fourth digest shares its slot with the one before it.
   task automatic build_pool();
      logic [DIGEST_W-1:0] t;
      for (int i = 0; i < POOL_SIZE; i++) begin
         t = rand64();
         if (i % 4 == 3) begin
            pool_hi[i] = $urandom_range(1) ? pool_hi[i-1] : rand64();
            pool_lo[i] = {t[DIGEST_W-1:SLOT_W], pool_lo[i-1][SLOT_W-1:0]};
         end else begin
            pool_hi[i] = rand64();
            pool_lo[i] = t;
         end
      end
      if ($urandom_range(1)) begin
         pool_hi[0] = '0;
         pool_lo[0] = '0;
      end
   endtask

   // Mostly pool digests with small epoch steps; some fresh digests and odd commands.
   task automatic random_word();
      int unsigned         pick, k;
      logic [CMD_W-1:0]    cmd;
      logic [DIGEST_W-1:0] hi, lo;
      logic [STEP_W-1:0]   step;
      k    = $urandom_range(POOL_SIZE - 1);
      hi   = pool_hi[k];
      lo   = pool_lo[k];
      step = $urandom;
      if ($urandom_range(99) < 12) begin
         hi = rand64();
         lo = rand64();
      end
      pick = $urandom_range(99);
      if (pick < 36)
         cmd = CMD_APPLY;
      else if (pick < 62)
         cmd = CMD_CHECK;
      else if (pick < 74)
         cmd = CMD_CLEAR;
      else if (pick < 76)
         cmd = CMD_CLEAR_ALL;
      else if (pick < 95) begin
         cmd  = CMD_ADVANCE;
         pick = $urandom_range(99);
         if (pick < 88)
            step = $urandom_range(3, 1);
         else if (pick < 97)
            step = $urandom_range(40);
      end else
         cmd = CMD_ADVANCE + CMD_W'($urandom_range(3, 1));   // undefined
      send_word(cmd, hi, lo, step);
   endtask

   initial begin
      logic [CUTOFF_W-1:0] phase_cutoff [PHASES];
      phase_cutoff = '{32'd0, 32'hFFFF_FFFF, 32'd3, 32'd12, 32'd1};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_cutoff(phase_cutoff[0]);
      directed_words();

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            settle();
            write_cutoff(phase_cutoff[p]);
         end
         build_pool();
         // one phase without idling; it opens with the long receiver hold-off
         calm = (p == 2);
         if (calm)
            hold_pending = 1'b1;
         repeat (WORDS_PER_PHASE) random_word();
      end
      calm = 1'b0;

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d apply, %0d check, %0d clear, %0d clear_all, %0d advance, %0d undefined.",
               cmd_seen[CMD_APPLY], cmd_seen[CMD_CHECK], cmd_seen[CMD_CLEAR],
               cmd_seen[CMD_CLEAR_ALL], cmd_seen[CMD_ADVANCE],
               cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
      $display("Cutoffs 0, max, 3, 12, 1; %0d responses checked, %0d hits, %0d mismatches.",
               responses, hits, errors);
      if (errors == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: filelist.f
src/adf_pkg.sv
src/adf_front.sv
src/adf_queue.sv
src/adf_back.sv
src/aging_duplicate_filter_unit.sv
src/adf_checker.sv
test/filter_checker.sv
test/tb.sv
